// ----- sv/ita_pkg.sv -----
package ita_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int MAX_DIGITS   = 64;
    localparam int RESULT_LIMIT = 63;
    localparam int STACK_DEPTH  = 64;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);

    localparam int IN_W    = 64;
    localparam int BASE_W  = 5;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 7;
    localparam int REM_W   = DIGIT_W + 1;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    // magnitude bits below the sign
    localparam int MAG_W    = VALUE_WIDTH - 1;
    // quotient bits retired per divider cycle
    localparam int DIV_BITS = 8;
    localparam int DIV_CYC  = (MAG_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W    = DIV_CYC * DIV_BITS;
    localparam int STEP_W   = $clog2(DIV_CYC + 1);

    localparam int LIMIT_A = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
    localparam int LIMIT   = (LIMIT_A < STACK_DEPTH) ? LIMIT_A : STACK_DEPTH;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F    = 8'h46;

    typedef struct packed {
        logic              err;
        logic [MAG_W-1:0]  mag;
        logic [BASE_W-1:0] base;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_RD,
        BK_OUT,
        BK_ERR
    } bk_state_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dd;
        dd = CHAR_W'(d);
        if (d < DIGIT_W'(10))
            glyph = CH_ZERO + dd;
        else
            glyph = CH_A + dd - CHAR_W'(10);
    endfunction

endpackage

// ----- sv/ita_ram.sv -----
module ita_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ita_front.sv -----
module ita_front
    import ita_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [IN_W-1:0]   value,
    input  logic [BASE_W-1:0] base,
    output logic              cmd_valid,
    output cmd_t              cmd_data,
    input  logic              cmd_take
);

    // two-entry command queue toward the back end
    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        do_push, do_pop;
    cmd_t        cls;

    always_comb
    begin
        cls.err  = (base < BASE_MIN) || (base > BASE_MAX) || value[VALUE_WIDTH-1];
        cls.mag  = value[MAG_W-1:0];
        cls.base = base;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ----- sv/ita_back.sv -----
module ita_back
    import ita_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd_data,
    output logic              cmd_take,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] char_code,
    output logic              last,
    output logic              error
);

    bk_state_t state_reg, state_next;

    logic [DIV_W-1:0]  work_reg, work_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] och_reg, och_next;
    logic              olast_reg, olast_next;
    logic              oerr_reg, oerr_next;

    // divider datapath: DIV_BITS restoring steps per cycle
    logic [DIV_W-1:0]  dw;
    logic [REM_W-1:0]  dr;

    logic                st_we, st_re;
    logic [STACK_AW-1:0] st_waddr, st_raddr;
    logic [DIGIT_W-1:0]  st_wdata, st_rdata;
    logic                out_free;

    ita_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_comb
    begin
        dr = rem_reg;
        dw = work_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            dr = {dr[REM_W-2:0], dw[DIV_W-1]};
            dw = {dw[DIV_W-2:0], 1'b0};
            if (dr >= REM_W'(base_reg))
            begin
                dr    = dr - REM_W'(base_reg);
                dw[0] = 1'b1;
            end
        end
    end

    assign out_free  = !ov_reg || pop;
    assign empty     = !ov_reg;
    assign char_code = och_reg;
    assign last      = olast_reg;
    assign error     = oerr_reg;

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        step_next  = step_reg;
        count_next = count_reg;
        ov_next    = ov_reg && !pop;
        och_next   = och_reg;
        olast_next = olast_reg;
        oerr_next  = oerr_reg;
        cmd_take   = 1'b0;
        st_we      = 1'b0;
        st_waddr   = count_reg[STACK_AW-1:0];
        st_wdata   = dr[DIGIT_W-1:0];
        st_re      = 1'b0;
        st_raddr   = STACK_AW'(count_reg - CNT_W'(1));

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    work_next  = DIV_W'(cmd_data.mag);
                    rem_next   = '0;
                    base_next  = cmd_data.base;
                    step_next  = '0;
                    count_next = '0;
                    state_next = cmd_data.err ? BK_ERR : BK_DIV;
                end
            end
            BK_DIV:
            begin
                work_next = dw;
                rem_next  = dr;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_CYC - 1))
                begin
                    // digit done: remainder to the stack, quotient stays in work
                    st_we      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    rem_next   = '0;
                    step_next  = '0;
                    if (dw == '0)
                        state_next = BK_RD;
                    else if (count_reg + CNT_W'(1) >= CNT_W'(LIMIT))
                        state_next = BK_ERR;
                end
            end
            BK_RD:
            begin
                st_re      = 1'b1;
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    och_next   = glyph(st_rdata);
                    olast_next = (count_reg == CNT_W'(1));
                    oerr_next  = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    state_next = (count_reg == CNT_W'(1)) ? BK_IDLE : BK_RD;
                end
            end
            BK_ERR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    och_next   = '0;
                    olast_next = 1'b1;
                    oerr_next  = 1'b1;
                    count_next = '0;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            work_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            work_reg  <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        base_reg  <= base_next;
        och_reg   <= och_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

endmodule

// ----- sv/integer_to_ascii_radix.sv -----
// Radix conversion: each word pushed carries a value and a base; the block
// pops out that value's digits in the base as uppercase ASCII ('0'-'9',
// 'A'-'F'), most significant first, one word per digit, with last set on
// the final digit. Zero gives the single digit '0'. A base outside 2..16
// or a negative value gives a single word with char_code 0, last 1 and
// error 1. Flow: the front end classifies the word and parks it in a
// two-entry command queue, so up to two words can be pushed while the
// back end is busy. The back end takes the command, then its one shared
// divider, which retires 8 quotient bits per cycle, runs over the whole
// 63-bit magnitude for each digit, and the remainder digit goes onto the
// digit stack RAM. The digits are then read back from the stack and
// loaded into the output register. The output register lets the back
// end go on while a finished word waits to be popped; it stalls only
// when it has the next word to load and the register is still full.
module integer_to_ascii_radix
    import ita_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [IN_W-1:0]   value,
    input  logic [BASE_W-1:0] base,
    output logic              empty,
    input  logic              pop,
    output logic [CHAR_W-1:0] char_code,
    output logic              last,
    output logic              error
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd_data;

    // classify and queue
    ita_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .base      (base),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_take  (cmd_take)
    );

    // divide, stack digits, emit in reverse
    ita_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last      (last),
        .error     (error)
    );

    // an error word is always a lone, final word
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> (last && (char_code == '0)))
        else $error("error word without last or with nonzero char");

    // a good word is always a valid digit glyph
    a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !error) |->
        ((char_code >= CH_ZERO && char_code <= CH_NINE) ||
         (char_code >= CH_A && char_code <= CH_F)))
        else $error("digit word is not a glyph");

    // the back end takes a command only when it sits idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> (cmd_valid && u_back.state_reg == BK_IDLE))
        else $error("command taken while back end busy");

endmodule
